[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL.
// Define ASSERT_OFF to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every clock edge outside reset.
`define ASSERT_PROP(label, clk_i, rst_ni, prop) \
    label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
        else $error("property violated");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk_i, rst_ni, expr) \
    label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk_i, rst_ni, prop)
`define ASSERT_NEVER(label, clk_i, rst_ni, expr)

`endif

`endif

[rtl/core/aip_pkg.sv]
package aip_pkg;

    localparam int VALUE_W = 64;
    localparam int POS_W   = 16;
    localparam int CHAR_W  = 8;
    localparam int CFG_W   = 5;
    localparam int DIGIT_W = 4;

    localparam longint unsigned MAX_POSITION_DEF = 64'd65535;
    localparam int              QUEUE_DEPTH_DEF  = 2;

    // Register indexes on the configuration port
    localparam logic REG_NUMBER_BASE = 1'b0;
    localparam logic REG_SIGNED_MODE = 1'b1;

    localparam logic [CFG_W-1:0] BASE_RESET   = 5'd10;
    localparam logic             SIGNED_RESET = 1'b1;

    localparam logic [CFG_W-1:0] BASE_2  = 5'd2;
    localparam logic [CFG_W-1:0] BASE_8  = 5'd8;
    localparam logic [CFG_W-1:0] BASE_10 = 5'd10;
    localparam logic [CFG_W-1:0] BASE_16 = 5'd16;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_1     = 8'h31;
    localparam logic [CHAR_W-1:0] CH_7     = 8'h37;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;

    typedef enum logic [1:0] {
        RADIX_2  = 2'd0,
        RADIX_8  = 2'd1,
        RADIX_10 = 2'd2,
        RADIX_16 = 2'd3
    } radix_t;

    typedef enum logic {
        OP_DIGIT = 1'b0,
        OP_EMIT  = 1'b1
    } op_kind_t;

    // Work handed from the front to the back
    typedef struct packed {
        op_kind_t           kind;
        radix_t             radix;
        logic [DIGIT_W-1:0] digit;
        logic               invalid;
        logic               neg;
        logic [POS_W-1:0]   pos;
    } op_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   pos;
        logic               invalid;
    } result_t;

    typedef struct packed {
        logic skip;
        logic neg;
    } front_status_t;

endpackage

[rtl/core/ascii_integer_parser_top.sv]
// A stop character is registered in the op queue, then in the result queue.
// Throughput: one character per cycle while full is low, set by the shift-and-add accumulator.
// A full result queue holds a stop beat at the head of the op queue; characters are still
// taken until that queue fills, then full rises until the stop drains.
// Reset (rst_n low, asynchronous): base 10, signed mode on, string state cleared,
// both queues emptied.
`include "assert_macros.svh"

module ascii_integer_parser_top
    import aip_pkg::*;
#(
    parameter longint unsigned MAX_POSITION = MAX_POSITION_DEF,
    parameter int              QUEUE_DEPTH  = QUEUE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    // character side
    input  logic               push,
    output logic               full,
    input  logic [CHAR_W-1:0]  char_code,
    // result side
    output logic               empty,
    input  logic               pop,
    output logic [VALUE_W-1:0] parsed_value,
    output logic [POS_W-1:0]   stop_position,
    output logic               stopped_by_invalid,
    // configuration
    input  logic               cfg_wr_en,
    input  logic               cfg_index,
    input  logic [CFG_W-1:0]   cfg_data
);

    // Configuration registers
    logic [CFG_W-1:0] number_base_reg, number_base_next;
    logic             signed_mode_reg, signed_mode_next;

    // Front to back queue
    logic          accept;
    logic          op_push, op_pop, op_full, op_empty;
    op_t           op_in, op_out;
    front_status_t front_st;

    // Back to result queue
    logic    res_push, res_full;
    result_t res_in, res_out;

    // Decode configuration writes; hold otherwise
    always_comb
    begin
        number_base_next = number_base_reg;
        signed_mode_next = signed_mode_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_NUMBER_BASE: number_base_next = cfg_data;
                REG_SIGNED_MODE: signed_mode_next = cfg_data[0];
                default:         number_base_next = number_base_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_base_reg <= BASE_RESET;
            signed_mode_reg <= SIGNED_RESET;
        end
        else
        begin
            number_base_reg <= number_base_next;
            signed_mode_reg <= signed_mode_next;
        end
    end

    // A character beat is taken whenever the op queue has room, even if it
    // turns out to be dropped (sign, skipped text)
    assign full   = op_full;
    assign accept = push && !op_full;

    // Front: classify characters, track sign, position and skipping
    aip_front #(
        .MAX_POSITION (MAX_POSITION)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .char_code   (char_code),
        .number_base (number_base_reg),
        .signed_mode (signed_mode_reg),
        .op_push     (op_push),
        .op          (op_in),
        .status      (front_st)
    );

    // Short queue decouples classification from accumulation
    aip_fifo #(
        .WIDTH ($bits(op_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_op_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (op_push),
        .wr_data (op_in),
        .full    (op_full),
        .rd_en   (op_pop),
        .rd_data (op_out),
        .empty   (op_empty)
    );

    // Back: advance the accumulator, form results at a stop
    aip_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_empty (op_empty),
        .op       (op_out),
        .op_pop   (op_pop),
        .res_full (res_full),
        .res_push (res_push),
        .res      (res_in)
    );

    // Result queue: results wait here while the next string streams in
    aip_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_out),
        .empty   (empty)
    );

    assign parsed_value       = res_out.value;
    assign stop_position      = res_out.pos;
    assign stopped_by_invalid = res_out.invalid;

    // A terminator always leaves the front ready for a fresh string
    `ASSERT_PROP(a_nul_clears, clk, rst_n, accept && char_code == CH_NUL |=> !front_st.skip && !front_st.neg)
    // Skipping drops the sign with the rest of the string
    `ASSERT_NEVER(a_skip_no_sign, clk, rst_n, front_st.skip && front_st.neg)
    // No stop op is issued while the rest of a string is being skipped
    `ASSERT_NEVER(a_skip_no_op, clk, rst_n, front_st.skip && op_push && (op_in.kind == OP_EMIT))
    // The back never writes a result into a full queue
    `ASSERT_NEVER(a_res_overrun, clk, rst_n, res_push && res_full)

endmodule

[rtl/core/aip_fifo.sv]
module aip_fifo
    import aip_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[rtl/core/aip_front.sv]
module aip_front
    import aip_pkg::*;
#(
    parameter longint unsigned MAX_POSITION = MAX_POSITION_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [CHAR_W-1:0] char_code,
    input  logic [CFG_W-1:0]  number_base,
    input  logic              signed_mode,
    output logic              op_push,
    output op_t               op,
    output front_status_t     status
);

    localparam int IDX_W = $clog2(MAX_POSITION + 64'd1);
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_POSITION);

    logic [IDX_W-1:0]   idx_reg, idx_next, idx_adv;
    logic               neg_reg, neg_next;
    logic               skip_reg, skip_next;
    logic               radix_ok;
    radix_t             radix;
    logic               is_dec, is_lower, is_upper, digit_ok;
    logic [DIGIT_W-1:0] digit;
    logic [POS_W-1:0]   pos;

    assign status.skip = skip_reg;
    assign status.neg  = neg_reg;

    // Radix decode; any other base makes all but NUL and a signed-mode leading minus invalid
    always_comb
    begin
        radix_ok = 1'b1;
        radix    = RADIX_10;
        unique case (number_base)
            BASE_2:  radix = RADIX_2;
            BASE_8:  radix = RADIX_8;
            BASE_10: radix = RADIX_10;
            BASE_16: radix = RADIX_16;
            default: radix_ok = 1'b0;
        endcase
    end

    assign is_dec   = (char_code >= CH_0)  && (char_code <= CH_9);
    assign is_lower = (char_code >= CH_LA) && (char_code <= CH_LF);
    assign is_upper = (char_code >= CH_UA) && (char_code <= CH_UF);

    always_comb
    begin
        digit    = char_code[DIGIT_W-1:0];
        digit_ok = 1'b0;
        unique case (radix)
            RADIX_2:  digit_ok = (char_code >= CH_0) && (char_code <= CH_1);
            RADIX_8:  digit_ok = (char_code >= CH_0) && (char_code <= CH_7);
            RADIX_10: digit_ok = is_dec;
            RADIX_16:
            begin
                digit_ok = is_dec || is_lower || is_upper;
                // letters: low nibble 1..6 maps to 10..15
                if (!is_dec)
                begin
                    digit = char_code[DIGIT_W-1:0] + 4'd9;
                end
            end
            default: digit_ok = 1'b0;
        endcase
        digit_ok = digit_ok && radix_ok;
    end

    assign idx_adv = (idx_reg == IDX_MAX) ? idx_reg : idx_reg + 1'b1;

    // Clamp the position to the width of the result field
    always_comb
    begin
        if (64'(idx_reg) > 64'(16'hFFFF))
        begin
            pos = '1;
        end
        else
        begin
            pos = POS_W'(idx_reg);
        end
    end

    always_comb
    begin
        idx_next   = idx_reg;
        neg_next   = neg_reg;
        skip_next  = skip_reg;
        op_push    = 1'b0;
        op.kind    = OP_DIGIT;
        op.radix   = radix;
        op.digit   = digit;
        op.invalid = 1'b0;
        op.neg     = neg_reg;
        op.pos     = pos;
        if (accept)
        begin
            if (skip_reg)
            begin
                // drop the rest of the string; NUL clears
                if (char_code == CH_NUL)
                begin
                    idx_next  = '0;
                    neg_next  = 1'b0;
                    skip_next = 1'b0;
                end
            end
            else if (char_code == CH_NUL)
            begin
                op_push  = 1'b1;
                op.kind  = OP_EMIT;
                idx_next = '0;
                neg_next = 1'b0;
            end
            else if ((char_code == CH_MINUS) && (idx_reg == '0) && !neg_reg && signed_mode)
            begin
                neg_next = 1'b1;
                idx_next = idx_adv;
            end
            else if (digit_ok)
            begin
                op_push  = 1'b1;
                idx_next = idx_adv;
            end
            else
            begin
                op_push    = 1'b1;
                op.kind    = OP_EMIT;
                op.invalid = 1'b1;
                idx_next   = '0;
                neg_next   = 1'b0;
                skip_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            neg_reg  <= 1'b0;
            skip_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            neg_reg  <= neg_next;
            skip_reg <= skip_next;
        end
    end

endmodule

[rtl/core/aip_back.sv]
module aip_back
    import aip_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    op_empty,
    input  op_t     op,
    output logic    op_pop,
    input  logic    res_full,
    output logic    res_push,
    output result_t res
);

    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic [VALUE_W-1:0] digit_ext;
    logic [VALUE_W-1:0] scaled;

    // Digits never wait; a stop waits for room in the result queue
    assign op_pop   = !op_empty && ((op.kind == OP_DIGIT) || !res_full);
    assign res_push = op_pop && (op.kind == OP_EMIT);

    assign digit_ext = VALUE_W'(op.digit);

    always_comb
    begin
        unique case (op.radix)
            RADIX_2:  scaled = {acc_reg[VALUE_W-2:0], 1'b0};
            RADIX_8:  scaled = {acc_reg[VALUE_W-4:0], 3'b000};
            RADIX_10: scaled = {acc_reg[VALUE_W-4:0], 3'b000} + {acc_reg[VALUE_W-2:0], 1'b0};
            RADIX_16: scaled = {acc_reg[VALUE_W-5:0], 4'b0000};
            default:  scaled = acc_reg;
        endcase
    end

    assign res.value   = op.neg ? (VALUE_W'(0) - acc_reg) : acc_reg;
    assign res.pos     = op.pos;
    assign res.invalid = op.invalid;

    always_comb
    begin
        acc_next = acc_reg;
        if (op_pop)
        begin
            if (op.kind == OP_EMIT)
            begin
                acc_next = '0;
            end
            else
            begin
                acc_next = scaled + digit_ext;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

endmodule
